// File: hdl/slotted_record_fifo_core_assert.svh
// Assertion macros used by the checker of the slotted record FIFO.
`ifndef SLOTTED_RECORD_FIFO_CORE_ASSERT_SVH
`define SLOTTED_RECORD_FIFO_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srf_pkg.sv
// Types and constants shared by the slotted record FIFO modules.
`default_nettype none

package srf_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int BLEN_W      = 16;
  localparam int STAT_W      = 3;
  localparam int SIZE_CFG_W  = 7;
  localparam int COUNT_CFG_W = 6;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int S_TDATA_W   = 24;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 16;
  localparam int M_TUSER_W   = 3;

  localparam logic [SIZE_CFG_W-1:0]  SLOT_SIZE_RST  = 7'd64;
  localparam logic [COUNT_CFG_W-1:0] SLOT_COUNT_RST = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_SIZE  = 1'b0,
    CFG_SLOT_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_SMALL = 3'd2,
    ST_FULL  = 3'd3,
    ST_LONG  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_MOD,
    S_PUSH_END,
    S_POP_CHK,
    S_POP_RUN,
    S_POP_MOD
  } state_t;

  typedef enum logic [1:0] {
    OUT_PUSH,
    OUT_POP_ERR,
    OUT_POP_BYTE
  } out_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     accept;
    logic     mod_start;
    logic     mod_from_read;
    logic     push_finish;
    logic     pop_start;
    logic     rd_issue;
    logic     rs_advance;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic mod_done;
    logic pop_small;
    logic pop_empty;
    logic rd_pend;
    logic rd_more;
    logic byte_last;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/srf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/srf_ctrl.sv
// Control state machine of the slotted record FIFO.
`default_nettype none

module srf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          req,
  input  wire logic          rlast,
  input  wire srf_pkg::sts_t sts,
  output      logic          in_ready,
  output      srf_pkg::cmd_t cmd
);

  srf_pkg::state_t state;
  srf_pkg::state_t state_next;
  logic            accept;
  logic            byte_load;

  // A result waiting in the output register does not hold off new input items.
  assign in_ready  = (state == srf_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign byte_load = sts.rd_pend && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srf_pkg::S_IDLE: begin
        if (accept) begin
          if (req == srf_pkg::REQ_POP) begin
            state_next = srf_pkg::S_POP_CHK;
          end else if (rlast) begin
            state_next = srf_pkg::S_PUSH_MOD;
          end
        end
      end
      srf_pkg::S_PUSH_MOD: begin
        if (sts.mod_done) begin
          state_next = srf_pkg::S_PUSH_END;
        end
      end
      srf_pkg::S_PUSH_END: begin
        if (sts.out_free) begin
          state_next = srf_pkg::S_IDLE;
        end
      end
      srf_pkg::S_POP_CHK: begin
        if (sts.out_free) begin
          if (sts.pop_small || sts.pop_empty) begin
            state_next = srf_pkg::S_IDLE;
          end else begin
            state_next = srf_pkg::S_POP_RUN;
          end
        end
      end
      srf_pkg::S_POP_RUN: begin
        if (byte_load && sts.byte_last) begin
          state_next = srf_pkg::S_POP_MOD;
        end
      end
      srf_pkg::S_POP_MOD: begin
        if (sts.mod_done) begin
          state_next = srf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd               = '0;
    cmd.out_sel       = srf_pkg::OUT_PUSH;
    cmd.accept        = accept;
    unique case (state)
      srf_pkg::S_IDLE: begin
        if (accept && (req == srf_pkg::REQ_PUSH) && rlast) begin
          cmd.mod_start = 1'b1;
        end
      end
      srf_pkg::S_PUSH_MOD: begin
      end
      srf_pkg::S_PUSH_END: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.push_finish = 1'b1;
        end
      end
      srf_pkg::S_POP_CHK: begin
        if (sts.out_free) begin
          if (sts.pop_small || sts.pop_empty) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = srf_pkg::OUT_POP_ERR;
          end else begin
            cmd.pop_start = 1'b1;
          end
        end
      end
      srf_pkg::S_POP_RUN: begin
        cmd.out_sel  = srf_pkg::OUT_POP_BYTE;
        cmd.out_load = byte_load;
        // Keep one read in flight: issue when the read register is empty or drains now.
        cmd.rd_issue = sts.rd_more && (!sts.rd_pend || byte_load);
        if (byte_load && sts.byte_last) begin
          cmd.mod_start     = 1'b1;
          cmd.mod_from_read = 1'b1;
        end
      end
      srf_pkg::S_POP_MOD: begin
        cmd.rs_advance = sts.mod_done;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/srf_dp.sv
// Datapath of the slotted record FIFO: settings, slot pointers, stores and result register.
`default_nettype none

module srf_dp #(
  parameter int MAX_SLOT_BYTES = 64,
  parameter int MAX_SLOTS      = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [srf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srf_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             req,
  input  wire logic [srf_pkg::BYTE_W-1:0]       data_byte,
  input  wire logic                             byte_valid,
  input  wire logic                             rlast,
  input  wire logic [srf_pkg::BLEN_W-1:0]       buf_len,
  input  wire srf_pkg::cmd_t                    cmd,
  output      srf_pkg::sts_t                    sts,
  input  wire logic                             out_ready,
  output      logic                             out_valid,
  output      logic [srf_pkg::BYTE_W-1:0]       out_byte,
  output      logic [srf_pkg::LEN_W-1:0]        out_length,
  output      logic [srf_pkg::STAT_W-1:0]       status,
  output      logic                             last
);

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int BW    = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
  localparam int DEPTH = MAX_SLOTS * (2 ** BW);
  localparam int CMPW  = (CW > srf_pkg::COUNT_CFG_W) ? CW : srf_pkg::COUNT_CFG_W;
  localparam int MCW   = $clog2(CW + 1);
  localparam int LW    = srf_pkg::LEN_W;

  localparam logic [LW-1:0]   MAXB     = LW'(MAX_SLOT_BYTES);
  localparam logic [LW-1:0]   MAXB_SAT = LW'(MAX_SLOT_BYTES + 1);
  localparam logic [CMPW-1:0] MAXS     = CMPW'(MAX_SLOTS);

  // Settings.
  logic [srf_pkg::SIZE_CFG_W-1:0]  cfg_size;
  logic [srf_pkg::COUNT_CFG_W-1:0] cfg_count;
  logic [LW-1:0]                   eff_size;
  logic [CW-1:0]                   eff_count;
  logic [CMPW-1:0]                 count_ext;

  // Pointers and push state.
  logic [SW-1:0]        ws;
  logic [SW-1:0]        rs;
  logic [LW-1:0]        br;
  logic [LW-1:0]        br_inc;
  logic [LW-1:0]        push_len;
  logic                 push_acc;
  logic                 pop_acc;
  logic                 byte_we;
  srf_pkg::status_t     push_status;
  logic                 commit;

  // Length store with valid bits; an entry never committed reads as zero.
  logic [MAX_SLOTS-1:0] len_vld;
  logic [LW-1:0]        len_q;
  logic [LW-1:0]        len_now;

  // Pop state.
  logic [srf_pkg::BLEN_W-1:0] blen_q;
  logic [LW-1:0]              pop_len;
  logic [LW-1:0]              rd_idx;
  logic [LW-1:0]              out_idx;
  logic                       rd_pend;
  logic [srf_pkg::BYTE_W-1:0] byte_q;
  logic [SW+BW-1:0]           bram_waddr;
  logic [SW+BW-1:0]           bram_raddr;

  // Remainder unit for slot wrap.
  logic          mod_busy;
  logic          mod_done;
  logic [MCW-1:0] mod_cnt;
  logic [CW-1:0] mod_x;
  logic [CW-1:0] mod_rem;
  logic [SW-1:0] mod_res;
  logic [CW-1:0] mod_in;
  logic [CW-1:0] mod_diff;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_new;

  // Result register.
  logic byte_last;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size  <= srf_pkg::SLOT_SIZE_RST;
      cfg_count <= srf_pkg::SLOT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (srf_pkg::cfg_reg_t'(cfg_index))
        srf_pkg::CFG_SLOT_SIZE:  cfg_size  <= cfg_data;
        srf_pkg::CFG_SLOT_COUNT: cfg_count <= cfg_data[srf_pkg::COUNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cfg_size == '0) begin
      eff_size = LW'(1);
    end else if (cfg_size > MAXB) begin
      eff_size = MAXB;
    end else begin
      eff_size = cfg_size;
    end
    count_ext = CMPW'(cfg_count);
    if (count_ext == '0) begin
      eff_count = CW'(1);
    end else if (count_ext > MAXS) begin
      eff_count = CW'(MAX_SLOTS);
    end else begin
      eff_count = CW'(count_ext);
    end
  end

  // Push side.
  assign push_acc = cmd.accept && (req == srf_pkg::REQ_PUSH);
  assign pop_acc  = cmd.accept && (req == srf_pkg::REQ_POP);
  assign byte_we  = push_acc && byte_valid && (br < MAXB);
  assign br_inc   = (byte_valid && (br < MAXB_SAT)) ? br + LW'(1) : br;

  always_comb begin
    if (push_len > eff_size) begin
      push_status = srf_pkg::ST_LONG;
    end else if (mod_res == rs) begin
      push_status = srf_pkg::ST_FULL;
    end else begin
      push_status = srf_pkg::ST_OK;
    end
  end

  assign commit = cmd.push_finish && (push_status == srf_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      br <= '0;
    end else if (push_acc) begin
      br <= rlast ? '0 : br_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc && rlast) begin
      push_len <= br_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws      <= '0;
      rs      <= '0;
      len_vld <= '0;
    end else begin
      if (commit) begin
        ws          <= mod_res;
        len_vld[ws] <= 1'b1;
      end
      if (cmd.rs_advance) begin
        rs <= mod_res;
      end
    end
  end

  srf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (ws),
    .wdata (push_len),
    .re    (pop_acc),
    .raddr (rs),
    .rdata (len_q)
  );

  assign bram_waddr = {ws, br[BW-1:0]};
  assign bram_raddr = {rs, rd_idx[BW-1:0]};

  srf_ram #(
    .WIDTH (srf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (bram_waddr),
    .wdata (data_byte),
    .re    (cmd.rd_issue),
    .raddr (bram_raddr),
    .rdata (byte_q)
  );

  // Pop side. The buffer check uses the head length even if the ring is empty.
  assign len_now = len_vld[rs] ? len_q : '0;

  always_ff @(posedge clk) begin
    if (pop_acc) begin
      blen_q <= buf_len;
    end
    if (cmd.pop_start) begin
      pop_len <= len_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      out_idx <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.pop_start) begin
      rd_idx  <= '0;
      out_idx <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.rd_issue) begin
        rd_idx <= rd_idx + LW'(1);
      end
      if (cmd.rd_issue) begin
        rd_pend <= 1'b1;
      end else if (cmd.out_load && (cmd.out_sel == srf_pkg::OUT_POP_BYTE)) begin
        rd_pend <= 1'b0;
      end
      if (cmd.out_load && (cmd.out_sel == srf_pkg::OUT_POP_BYTE)) begin
        out_idx <= out_idx + LW'(1);
      end
    end
  end

  assign byte_last = (out_idx == eff_size - LW'(1));

  // Remainder of a slot index plus one by the slot count. Values below twice the
  // count finish at once; larger ones take one bit per cycle.
  assign mod_in   = cmd.mod_from_read ? CW'(rs) + CW'(1) : CW'(ws) + CW'(1);
  assign mod_diff = mod_in - eff_count;
  assign rem_sh   = {mod_rem, mod_x[CW-1]};
  assign rem_new  = (rem_sh >= {1'b0, eff_count}) ? rem_sh - {1'b0, eff_count} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      mod_done <= 1'b0;
    end else begin
      mod_done <= 1'b0;
      if (cmd.mod_start) begin
        if (mod_in < eff_count) begin
          mod_done <= 1'b1;
        end else if (mod_diff < eff_count) begin
          mod_done <= 1'b1;
        end else begin
          mod_busy <= 1'b1;
        end
      end else if (mod_busy && (mod_cnt == MCW'(1))) begin
        mod_busy <= 1'b0;
        mod_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mod_x   <= mod_in;
      mod_rem <= '0;
      mod_cnt <= MCW'(CW);
      if (mod_in < eff_count) begin
        mod_res <= SW'(mod_in);
      end else if (mod_diff < eff_count) begin
        mod_res <= SW'(mod_diff);
      end
    end else if (mod_busy) begin
      mod_x   <= mod_x << 1;
      mod_rem <= CW'(rem_new);
      mod_cnt <= mod_cnt - MCW'(1);
      if (mod_cnt == MCW'(1)) begin
        mod_res <= SW'(rem_new);
      end
    end
  end

  // Result register.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        srf_pkg::OUT_PUSH: begin
          out_byte   <= '0;
          out_length <= (push_status == srf_pkg::ST_OK) ? push_len : '0;
          status     <= push_status;
          last       <= 1'b1;
        end
        srf_pkg::OUT_POP_ERR: begin
          out_byte   <= '0;
          out_length <= '0;
          status     <= (blen_q < srf_pkg::BLEN_W'(len_now)) ? srf_pkg::ST_SMALL
                                                             : srf_pkg::ST_EMPTY;
          last       <= 1'b1;
        end
        srf_pkg::OUT_POP_BYTE: begin
          out_byte   <= (out_idx < pop_len) ? byte_q : '0;
          out_length <= pop_len;
          status     <= srf_pkg::ST_OK;
          last       <= byte_last;
        end
        default: begin
          out_byte   <= '0;
          out_length <= '0;
          status     <= srf_pkg::ST_OK;
          last       <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts           = '0;
    sts.out_free  = out_free;
    sts.mod_done  = mod_done;
    sts.pop_small = blen_q < srf_pkg::BLEN_W'(len_now);
    sts.pop_empty = (ws == rs);
    sts.rd_pend   = rd_pend;
    sts.rd_more   = rd_idx < eff_size;
    sts.byte_last = byte_last;
  end

endmodule

`default_nettype wire

// File: hdl/slotted_record_fifo_core.sv
// Slotted record FIFO: ring of fixed-size slots holding variable-length byte records.
//
// Push items stream record bytes into the free slot, one item per cycle while the
// block is idle. The item with tlast set closes the record and produces one result
// (ok, full or too long); it keeps the block busy while the remainder unit finds the
// next slot index, directly when it does not wrap past twice the slot count, else
// through the bit-serial loop for an index left beyond a reduced slot_count, and until
// the result register is free. A pop reads and checks the head length (an error result
// then ends it) and then returns slot_size result items at one per cycle while the
// output is not stalled, paced by the read port of the slot byte RAM, and then
// advances the read slot. The length store is cleared at reset through per-slot
// valid bits, so no clearing pass is needed.
`default_nettype none

module slotted_record_fifo_core #(
  parameter int MAX_SLOT_BYTES = 64,
  parameter int MAX_SLOTS      = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [srf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srf_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // data_byte[7:0], buf_len[23:8]
  input  wire logic [srf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type[0], byte_valid[1]
  input  wire logic [srf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_byte[7:0], out_length[14:8], zero[15]
  output      logic [srf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // status[2:0]
  output      logic [srf_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output      logic                            m_axis_tlast
);

  srf_pkg::cmd_t              cmd;
  srf_pkg::sts_t              sts;
  logic [srf_pkg::BYTE_W-1:0] out_byte;
  logic [srf_pkg::LEN_W-1:0]  out_length;

  srf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req      (s_axis_tuser[0]),
    .rlast    (s_axis_tlast),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  srf_dp #(
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES),
    .MAX_SLOTS      (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (s_axis_tuser[0]),
    .data_byte  (s_axis_tdata[7:0]),
    .byte_valid (s_axis_tuser[1]),
    .rlast      (s_axis_tlast),
    .buf_len    (s_axis_tdata[23:8]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_byte   (out_byte),
    .out_length (out_length),
    .status     (m_axis_tuser),
    .last       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_length, out_byte};

endmodule

`default_nettype wire

// File: hdl/srf_checker.sv
// Port-level checker for the slotted record FIFO, bound to the top level.
`default_nettype none

`include "slotted_record_fifo_core_assert.svh"

module srf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [srf_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input wire logic                          s_axis_tlast,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [srf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [srf_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  // A stalled result item must hold.
  `SRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result item changed while stalled")

  // An error result is a single item with no payload.
  `SRF_ASSERT_NOW(a_err_last, m_axis_tvalid && (m_axis_tuser != srf_pkg::ST_OK), m_axis_tlast && (m_axis_tdata == '0), "error result is not a lone empty item")

  // Status codes above too long never appear.
  `SRF_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser <= srf_pkg::ST_LONG, "undefined status code")

  // A pop or a record end leaves the block busy, so no input is taken right after it.
  `SRF_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] || s_axis_tlast), !s_axis_tready, "input taken right after a pop or record end")

endmodule

bind slotted_record_fifo_core srf_checker u_srf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: verif/slotted_record_fifo_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slotted record FIFO core.
module slotted_record_fifo_core_tb;

  localparam int SLOT_BYTES    = 64;
  localparam int SLOTS         = 32;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    srf_pkg::req_t req;
    logic [7:0]    data;
    logic          valid;
    logic          rlast;
    logic [15:0]   blen;
  } fifo_req_t;

  typedef struct {
    logic [7:0]       dbyte;
    logic [6:0]       len;
    srf_pkg::status_t st;
    logic             last;
  } fifo_result_t;

  typedef enum { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    srf_pkg::cfg_reg_t idx;
    logic [6:0]        val;
    fifo_req_t         it;
    logic              typed;
    srf_pkg::status_t  st;
    logic [6:0]        len;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  srf_pkg::cfg_reg_t cfg_index;
  logic [srf_pkg::CFG_W-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [srf_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [srf_pkg::S_TUSER_W-1:0] s_axis_tuser;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [srf_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [srf_pkg::M_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  // Shadow copy of the ring, used to work out the expected results.
  logic [7:0] slot_mem [SLOTS][SLOT_BYTES];
  logic [6:0] len_mem [SLOTS];
  int unsigned wr_slot;
  int unsigned rd_slot;
  int unsigned rx_count;
  logic [6:0] size_reg;
  logic [5:0] count_reg;

  fifo_result_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  slotted_record_fifo_core #(
    .MAX_SLOT_BYTES(SLOT_BYTES),
    .MAX_SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned size_now();
    if (size_reg == 0) return 1;
    if (size_reg > SLOT_BYTES) return SLOT_BYTES;
    return size_reg;
  endfunction

  function automatic int unsigned count_now();
    if (count_reg == 0) return 1;
    if (count_reg > SLOTS) return SLOTS;
    return count_reg;
  endfunction

  // Applies one accepted item to the shadow ring and queues what it yields.
  function automatic void predict_item(fifo_req_t it);
    int unsigned size;
    int unsigned count;
    int unsigned w;
    int unsigned r;
    int unsigned len;
    int unsigned nxt;
    fifo_result_t res;
    size = size_now();
    count = count_now();
    w = wr_slot % SLOTS;
    r = rd_slot % SLOTS;
    res.dbyte = 8'd0;
    res.len = 7'd0;
    res.st = srf_pkg::ST_OK;
    res.last = 1'b1;
    if (it.req == srf_pkg::REQ_PUSH) begin
      if (it.valid) begin
        if (rx_count < SLOT_BYTES) slot_mem[w][rx_count] = it.data;
        if (rx_count < SLOT_BYTES + 1) rx_count++;
      end
      if (!it.rlast) return;
      len = rx_count;
      rx_count = 0;
      if (len > size) begin
        res.st = srf_pkg::ST_LONG;
      end else begin
        nxt = (wr_slot + 1) % count;
        if (nxt == rd_slot) begin
          res.st = srf_pkg::ST_FULL;
        end else begin
          len_mem[w] = len[6:0];
          wr_slot = nxt;
          res.len = len[6:0];
        end
      end
      pending_results.push_back(res);
    end else begin
      len = len_mem[r];
      if (it.blen < len) begin
        res.st = srf_pkg::ST_SMALL;
        pending_results.push_back(res);
      end else if (wr_slot == rd_slot) begin
        res.st = srf_pkg::ST_EMPTY;
        pending_results.push_back(res);
      end else begin
        for (int i = 0; i < size; i++) begin
          res.dbyte = (i < len) ? slot_mem[r][i] : 8'd0;
          res.len = len[6:0];
          res.last = (i + 1 == size);
          pending_results.push_back(res);
        end
        rd_slot = (rd_slot + 1) % count;
      end
    end
  endfunction

  task automatic send_item(fifo_req_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.blen, it.data};
    s_axis_tuser <= {it.valid, it.req};
    s_axis_tlast <= it.rlast;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(it);
    // A push filler with no byte and no end changes nothing.
    if (!(it.req == srf_pkg::REQ_PUSH && !it.valid && !it.rlast)) items_sent++;
  endtask

  // Stops offering items and waits until every result is in and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(srf_pkg::cfg_reg_t idx, logic [6:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srf_pkg::CFG_SLOT_SIZE) size_reg = val;
    else count_reg = val[5:0];
  endtask

  function automatic fifo_req_t pop_req(logic [15:0] bl);
    fifo_req_t it;
    it.req = srf_pkg::REQ_POP;
    it.data = 8'($urandom);
    it.valid = 1'($urandom);
    it.rlast = 1'($urandom);
    it.blen = bl;
    return it;
  endfunction

  task automatic send_record(int nbytes);
    fifo_req_t it;
    it.req = srf_pkg::REQ_PUSH;
    if (nbytes == 0) begin
      it.data = 8'($urandom);
      it.valid = 1'b0;
      it.rlast = 1'b1;
      it.blen = 16'($urandom);
      send_item(it);
    end
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.data = 8'($urandom);
        it.valid = 1'b0;
        it.rlast = 1'b0;
        it.blen = 16'($urandom);
        send_item(it);
      end
      it.data = 8'($urandom);
      it.valid = 1'b1;
      it.rlast = (i == nbytes - 1);
      it.blen = 16'($urandom);
      send_item(it);
    end
  endtask

  task automatic run_random(int quota);
    int stop;
    int p;
    int cap;
    int unsigned head;
    logic [15:0] bl;
    fifo_req_t it;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      p = $urandom_range(0, 99);
      cap = (size_now() < 6) ? size_now() : 6;
      if (p < 50) begin
        p = $urandom_range(0, 99);
        if (p < 75) send_record($urandom_range(0, cap));
        else if (p < 88) send_record(cap);
        else if (size_now() <= 8) send_record(size_now() + $urandom_range(1, 2));
        else send_record(cap);
      end else if (p < 85) begin
        head = len_mem[rd_slot % SLOTS];
        p = $urandom_range(0, 99);
        if (p < 45) bl = 16'($urandom_range(64, 65535));
        else if (p < 65) bl = head[15:0];
        else if (p < 80) bl = (head > 0) ? 16'(head - 1) : 16'd0;
        else bl = 16'($urandom);
        send_item(pop_req(bl));
      end else begin
        // Loose items: stray pops, lone bytes and record ends out of sequence.
        it.req = srf_pkg::req_t'($urandom_range(0, 1));
        it.data = 8'($urandom);
        it.valid = 1'($urandom);
        it.rlast = 1'($urandom);
        it.blen = 16'($urandom);
        send_item(it);
      end
    end
  endtask

  function automatic dir_row_t item_row(srf_pkg::req_t rq, logic [7:0] d, logic v, logic l,
                                        logic [15:0] bl, logic typed, srf_pkg::status_t st,
                                        logic [6:0] len);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.idx = srf_pkg::CFG_SLOT_SIZE;
    row.val = 7'd0;
    row.it = '{req: rq, data: d, valid: v, rlast: l, blen: bl};
    row.typed = typed;
    row.st = st;
    row.len = len;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(srf_pkg::cfg_reg_t idx, logic [6:0] val);
    dir_row_t row;
    row = item_row(srf_pkg::REQ_PUSH, 8'd0, 1'b0, 1'b0, 16'd0, 1'b0, srf_pkg::ST_OK, 7'd0);
    row.kind = ROW_CFG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  // The receiver stalls at random, and for a long stretch whenever one is asked for.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: out_byte %0h out_length %0d status %0d last %0b",
               m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.dbyte) begin
          $error("out_byte: expected %0h, got %0h", want.dbyte, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[14:8] !== want.len) begin
          $error("out_length: expected %0d, got %0d", want.len, m_axis_tdata[14:8]);
          mismatches++;
        end
        if (m_axis_tuser[2:0] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tuser[2:0]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("slotted_record_fifo_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows[$];
    fifo_result_t typed_res;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= srf_pkg::CFG_SLOT_SIZE;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    s_axis_tlast <= 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      len_mem[s] = 7'd0;
      for (int b = 0; b < SLOT_BYTES; b++) slot_mem[s][b] = 8'd0;
    end
    wr_slot = 0;
    rd_slot = 0;
    rx_count = 0;
    size_reg = srf_pkg::SLOT_SIZE_RST;
    count_reg = srf_pkg::SLOT_COUNT_RST;

    // Reset values first, then size and count forced to their clamped extremes.
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1,
                            srf_pkg::ST_EMPTY, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'hFF, 1'b0, 1'b1, 16'hFFFF, 1'b1,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1,
                            srf_pkg::ST_OK, 7'd2));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0001, 1'b1,
                            srf_pkg::ST_SMALL, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'hFF, 1'b1, 1'b1, 16'h0002, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(cfg_row(srf_pkg::CFG_SLOT_SIZE, 7'd0));
    rows.push_back(cfg_row(srf_pkg::CFG_SLOT_COUNT, 7'd0));
    // The write slot now sits beyond a count of one.
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h11, 1'b1, 1'b1, 16'h1234, 1'b1,
                            srf_pkg::ST_OK, 7'd1));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h22, 1'b1, 1'b0, 16'h0000, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h33, 1'b1, 1'b1, 16'h0000, 1'b1,
                            srf_pkg::ST_LONG, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1,
                            srf_pkg::ST_SMALL, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0001, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h44, 1'b1, 1'b1, 16'hFFFF, 1'b1,
                            srf_pkg::ST_FULL, 7'd0));
    rows.push_back(cfg_row(srf_pkg::CFG_SLOT_SIZE, 7'd127));
    rows.push_back(cfg_row(srf_pkg::CFG_SLOT_COUNT, 7'd2));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1,
                            srf_pkg::ST_EMPTY, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h80, 1'b1, 1'b0, 16'h0000, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h7F, 1'b1, 1'b0, 16'h0000, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h01, 1'b1, 1'b1, 16'h0000, 1'b1,
                            srf_pkg::ST_OK, 7'd3));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0003, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'hC3, 1'b1, 1'b0, 16'h0000, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h3C, 1'b1, 1'b1, 16'h0000, 1'b1,
                            srf_pkg::ST_OK, 7'd2));
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'hFFFF, 1'b0,
                            srf_pkg::ST_OK, 7'd0));
    // The ring is empty, but the head slot still holds an old length of three.
    rows.push_back(item_row(srf_pkg::REQ_POP, 8'h00, 1'b0, 1'b0, 16'h0002, 1'b1,
                            srf_pkg::ST_SMALL, 7'd0));
    rows.push_back(item_row(srf_pkg::REQ_PUSH, 8'h00, 1'b0, 1'b1, 16'h0000, 1'b1,
                            srf_pkg::ST_OK, 7'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        write_cfg(rows[k].idx, rows[k].val);
      end else begin
        send_item(rows[k].it);
        if (rows[k].typed) begin
          typed_res = '{dbyte: 8'd0, len: rows[k].len, st: rows[k].st, last: 1'b1};
          void'(pending_results.pop_back());
          pending_results.push_back(typed_res);
        end
      end
    end

    write_cfg(srf_pkg::CFG_SLOT_SIZE, 7'($urandom_range(2, 8)));
    write_cfg(srf_pkg::CFG_SLOT_COUNT, 7'($urandom_range(2, 6)));
    tx_idle_pct = 27;
    rx_idle_pct = 67;
    run_random(20);

    write_cfg(srf_pkg::CFG_SLOT_SIZE, 7'd64);
    write_cfg(srf_pkg::CFG_SLOT_COUNT, 7'd63);
    tx_idle_pct = 67;
    rx_idle_pct = 27;
    // A record of the full slot size, then one long enough to saturate the byte count.
    send_record(SLOT_BYTES);
    send_record(SLOT_BYTES + 2);
    send_item(pop_req(16'hFFFF));
    run_random(20);

    write_cfg(srf_pkg::CFG_SLOT_SIZE, 7'($urandom_range(1, 8)));
    write_cfg(srf_pkg::CFG_SLOT_COUNT, 7'($urandom_range(3, 31)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Hold the output off while short records keep coming, so the input backs up.
    hold_ask <= hold_ask + 1;
    repeat (8) send_record(1);
    settle();
    run_random(20);

    settle();
    if (mismatches == 0) begin
      $display("slotted_record_fifo_core_tb passed");
    end else begin
      $display("slotted_record_fifo_core_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/srf_pkg.sv
hdl/srf_ram.sv
hdl/srf_ctrl.sv
hdl/srf_dp.sv
hdl/slotted_record_fifo_core.sv
hdl/srf_checker.sv
verif/slotted_record_fifo_core_tb.sv
